>>> rtl/sliding_window_frame_rate_meter_macros.svh
// Assertion macros used by the frame rate meter top level.
`ifndef SLIDING_WINDOW_FRAME_RATE_METER_MACROS_SVH
`define SLIDING_WINDOW_FRAME_RATE_METER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWFRM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SWFRM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/swfrm_pkg.sv
// Shared constants and types of the sliding window frame rate meter.
package swfrm_pkg;

    // Window and time base.
    localparam int MAX_WINDOW = 64;
    localparam int TIME_WIDTH = 48;
    localparam int POS_W      = $clog2(MAX_WINDOW);
    localparam int LEN_W      = $clog2(MAX_WINDOW + 1);

    // Register field widths.
    localparam int WLEN_W     = 7;
    localparam int TPMS_W     = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_MS  = CFG_IDX_W'(1);

    // Register reset values.
    localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(30);
    localparam logic [TPMS_W-1:0] TPMS_RESET = TPMS_W'(1000);

    // Rate arithmetic: frames over milliseconds, scaled to Q8 per second.
    localparam int RATE_W   = 24;
    localparam int SCALE_Q8 = 256000;
    localparam int NUM_W    = $clog2((MAX_WINDOW - 1) * SCALE_Q8 + 1);
    localparam logic [NUM_W-1:0] Q8_SCALE = NUM_W'(SCALE_Q8);

    // Divider step counter must hold the widest division.
    localparam int STEPS_W = $clog2(TIME_WIDTH + 1);

    // Ring memory access for one cycle.
    typedef struct packed {
        logic                  we;
        logic [POS_W-1:0]      waddr;
        logic [TIME_WIDTH-1:0] wdata;
        logic [POS_W-1:0]      raddr;
    } t_ring_cmd;

    // Divider launch request.
    typedef struct packed {
        logic               start;
        logic [STEPS_W-1:0] steps;
    } t_div_req;

    // Divider status.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

>>> rtl/sliding_window_frame_rate_meter.sv
// Top level of the sliding window frame rate meter.
//
//  Channel | Handshake                     | Word
//  --------+-------------------------------+-------------------------------------
//  in      | i_in_valid / o_in_stall       | i_timestamp_ticks
//  out     | o_out_valid / i_out_stall     | o_rate_q8, o_rate_valid
//  cfg     | i_cfg_valid / o_cfg_ready     | i_cfg_index, i_cfg_data
//
// A mark with a valid rate goes through the ring read, then a division of elapsed ticks by
// ticks per ms and a division of the scaled frame count by the ms on the bit-serial divider.
// With fewer than two marks the result skips both divisions, with zero elapsed ms the second.
// Reset is synchronous and active low; the ring holds no reset and is read only where written.
// The next mark is accepted once the previous result sits in the output register;
// a stalled output word holds the following result back in the block.
`include "sliding_window_frame_rate_meter_macros.svh"

module sliding_window_frame_rate_meter
    import swfrm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [TIME_WIDTH-1:0] i_timestamp_ticks,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [RATE_W-1:0]     o_rate_q8,
    output logic                  o_rate_valid,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV1,
        ST_DIV2,
        ST_FINISH
    } t_state;

    t_state                r_state;
    logic [WLEN_W-1:0]     r_wlen;
    logic [TPMS_W-1:0]     r_tpms;
    logic [POS_W-1:0]      r_write_pos;
    logic                  r_full;
    logic [TIME_WIDTH-1:0] r_ts;
    logic [NUM_W-1:0]      r_numer;
    logic                  r_ge2;
    logic [RATE_W-1:0]     r_res_rate;
    logic                  r_res_valid;
    logic                  r_out_valid;
    logic [RATE_W-1:0]     r_out_rate;
    logic                  r_out_rvalid;

    logic                  in_accept;
    logic                  cfg_write;
    logic [LEN_W-1:0]      eff_len;
    logic [POS_W-1:0]      pos;
    logic [LEN_W-1:0]      nxt;
    logic                  wrap;
    logic [POS_W-1:0]      n_write_pos;
    logic                  n_full;
    logic [LEN_W-1:0]      count;
    logic [POS_W-1:0]      oldest;
    logic [NUM_W-1:0]      numer;
    logic [TIME_WIDTH-1:0] elapsed;
    logic [TIME_WIDTH-1:0] tpms_ext;
    logic [TIME_WIDTH-1:0] oldest_ts;
    logic [TIME_WIDTH-1:0] quotient;
    logic                  ms_zero;
    logic                  quo_over;
    logic                  out_free;
    t_ring_cmd             ring_cmd;
    t_div_req              div_req;
    t_div_stat             div_stat;
    logic [TIME_WIDTH-1:0] div_dividend;
    logic [TIME_WIDTH-1:0] div_divisor;

    assign in_accept   = i_in_valid && !o_in_stall;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign out_free    = !r_out_valid || !i_out_stall;

    // Window bookkeeping for the mark being accepted.
    always_comb begin
        if (r_wlen == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_wlen > WLEN_W'(MAX_WINDOW)) begin
            eff_len = LEN_W'(MAX_WINDOW);
        end else begin
            eff_len = LEN_W'(r_wlen);
        end
        pos         = (LEN_W'(r_write_pos) < eff_len) ? r_write_pos : '0;
        nxt         = LEN_W'(pos) + LEN_W'(1);
        wrap        = (nxt >= eff_len);
        n_write_pos = wrap ? '0 : POS_W'(nxt);
        n_full      = r_full || wrap;
        count       = n_full ? eff_len : nxt;
        oldest      = n_full ? n_write_pos : '0;
        numer       = NUM_W'(count - LEN_W'(1)) * Q8_SCALE;
    end

    // Ring access: store the newest mark, fetch the oldest.
    always_comb begin
        ring_cmd.we    = in_accept;
        ring_cmd.waddr = pos;
        ring_cmd.wdata = i_timestamp_ticks;
        ring_cmd.raddr = oldest;
    end

    swfrm_ring u_ring (
        .i_clk   (i_clk),
        .i_cmd   (ring_cmd),
        .o_rdata (oldest_ts)
    );

    // Divider operands: ticks to ms first, then scaled frame count over ms.
    always_comb begin
        elapsed  = r_ts - oldest_ts;
        tpms_ext = (r_tpms == '0) ? TIME_WIDTH'(1) : TIME_WIDTH'(r_tpms);
        ms_zero  = (quotient == '0);
        quo_over = |quotient[TIME_WIDTH-1:RATE_W];
        div_req.start = ((r_state == ST_READ) && r_ge2)
                     || ((r_state == ST_DIV1) && div_stat.done && !ms_zero);
        if (r_state == ST_READ) begin
            div_req.steps = STEPS_W'(TIME_WIDTH);
            div_dividend  = elapsed;
            div_divisor   = tpms_ext;
        end else begin
            div_req.steps = STEPS_W'(NUM_W);
            div_dividend  = {r_numer, {(TIME_WIDTH - NUM_W){1'b0}}};
            div_divisor   = quotient;
        end
    end

    swfrm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (div_req),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_quotient (quotient)
    );

    // Configuration registers and window position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen      <= WLEN_RESET;
            r_tpms      <= TPMS_RESET;
            r_write_pos <= '0;
            r_full      <= 1'b0;
        end else if (cfg_write) begin
            unique case (i_cfg_index)
                CFG_WINDOW_LENGTH: begin
                    r_wlen      <= i_cfg_data[WLEN_W-1:0];
                    r_write_pos <= '0;
                    r_full      <= 1'b0;
                end
                CFG_TICKS_PER_MS: begin
                    r_tpms <= i_cfg_data[TPMS_W-1:0];
                end
                default: begin
                end
            endcase
        end else if (in_accept) begin
            r_write_pos <= n_write_pos;
            r_full      <= n_full;
        end
    end

    // Item sequencer with the result and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // In the finish state a taken word is replaced by the new one below.
            if (r_out_valid && !i_out_stall && (r_state != ST_FINISH)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_ts    <= i_timestamp_ticks;
                        r_numer <= numer;
                        r_ge2   <= (count >= LEN_W'(2));
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    if (r_ge2) begin
                        r_state <= ST_DIV1;
                    end else begin
                        r_res_rate  <= '0;
                        r_res_valid <= 1'b0;
                        r_state     <= ST_FINISH;
                    end
                end
                ST_DIV1: begin
                    if (div_stat.done) begin
                        if (ms_zero) begin
                            r_res_rate  <= '0;
                            r_res_valid <= 1'b0;
                            r_state     <= ST_FINISH;
                        end else begin
                            r_state <= ST_DIV2;
                        end
                    end
                end
                ST_DIV2: begin
                    if (div_stat.done) begin
                        r_res_rate  <= quo_over ? '1 : quotient[RATE_W-1:0];
                        r_res_valid <= 1'b1;
                        r_state     <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_rate   <= r_res_rate;
                        r_out_rvalid <= r_res_valid;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_rate_q8    = r_out_rate;
    assign o_rate_valid = r_out_rvalid;

    // An accepted mark always goes on to the ring read.
    `SWFRM_ASSERT_NEXT(a_accept_reads, i_clk, i_rst_n, in_accept, r_state == ST_READ, "accepted mark did not reach the read state")
    // The divider only runs while the sequencer waits on it.
    `SWFRM_ASSERT_SAME(a_div_owned, i_clk, i_rst_n, div_stat.busy, (r_state == ST_DIV1) || (r_state == ST_DIV2), "divider busy outside a division state")
    // The write position never leaves the current window.
    `SWFRM_ASSERT_SAME(a_pos_in_window, i_clk, i_rst_n, 1'b1, LEN_W'(r_write_pos) < eff_len, "write position beyond window length")
    // An invalid rate is always reported as zero.
    `SWFRM_ASSERT_SAME(a_invalid_zero, i_clk, i_rst_n, r_out_valid && !r_out_rvalid, r_out_rate == '0, "invalid rate word carries a nonzero rate")

endmodule

>>> rtl/swfrm_ring.sv
// Ring of frame mark timestamps, one write and one registered read port.
module swfrm_ring
    import swfrm_pkg::*;
(
    input  logic                  i_clk,
    input  t_ring_cmd             i_cmd,
    output logic [TIME_WIDTH-1:0] o_rdata
);

    logic [TIME_WIDTH-1:0] r_mem [MAX_WINDOW];
    logic [TIME_WIDTH-1:0] r_rdata;

    // Write the newest mark and read the oldest one in the same cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.we) begin
            r_mem[i_cmd.waddr] <= i_cmd.wdata;
        end
        r_rdata <= r_mem[i_cmd.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/swfrm_div.sv
// Restoring divider producing one quotient bit per cycle, shared by both divisions.
module swfrm_div
    import swfrm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_div_req              i_req,
    input  logic [TIME_WIDTH-1:0] i_dividend,
    input  logic [TIME_WIDTH-1:0] i_divisor,
    output t_div_stat             o_stat,
    output logic [TIME_WIDTH-1:0] o_quotient
);

    logic                  r_busy;
    logic                  r_done;
    logic [STEPS_W-1:0]    r_cnt;
    logic [TIME_WIDTH-1:0] r_rem;
    logic [TIME_WIDTH-1:0] r_dvd;
    logic [TIME_WIDTH-1:0] r_dvs;
    logic [TIME_WIDTH-1:0] r_quo;

    logic [TIME_WIDTH:0]   trial;
    logic [TIME_WIDTH:0]   diff;
    logic                  fits;

    // Bring down the next dividend bit and try the subtraction.
    always_comb begin
        trial = {r_rem, r_dvd[TIME_WIDTH-1]};
        diff  = trial - {1'b0, r_dvs};
        fits  = (trial >= {1'b0, r_dvs});
    end

    // Control: count steps, flag the last one.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && !i_req.start && (r_cnt == STEPS_W'(1));
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEPS_W'(1);
                if (r_cnt == STEPS_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Datapath: partial remainder, shifting dividend and quotient.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dvs <= i_divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= fits ? diff[TIME_WIDTH-1:0] : trial[TIME_WIDTH-1:0];
            r_dvd <= {r_dvd[TIME_WIDTH-2:0], 1'b0};
            r_quo <= {r_quo[TIME_WIDTH-2:0], fits};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;

endmodule

>>> tb/sliding_window_frame_rate_meter_checker.sv
// Checker for the frame rate meter: predicts every rate word and compares it at the output.
`timescale 1ns / 100ps

module sliding_window_frame_rate_meter_checker
    import swfrm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_stall,
    input  logic [TIME_WIDTH-1:0] i_timestamp_ticks,
    input  logic                  i_out_valid,
    input  logic                  i_out_stall,
    input  logic [RATE_W-1:0]     i_rate_q8,
    input  logic                  i_rate_valid,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatch_count,
    output int                    o_words_due
);

    localparam logic [RATE_W-1:0] RATE_CEIL = '1;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [RATE_W-1:0] rate_q8;
        logic              rate_valid;
    } t_rate_word;

    // Shadow copy of the meter state and its registers.
    logic [TIME_WIDTH-1:0] mark_store [MAX_WINDOW];
    int unsigned           next_slot = 0;
    bit                    ring_wrapped = 1'b0;
    logic [WLEN_W-1:0]     window_reg = WLEN_RESET;
    logic [TPMS_W-1:0]     tick_div_reg = TPMS_RESET;

    t_rate_word rate_words_due [$];
    int         mismatches = 0;

    // Store one mark in the window and work out the rate word it produces.
    function automatic t_rate_word rate_for_mark(input logic [TIME_WIDTH-1:0] stamp);
        int unsigned           span;
        int unsigned           slot;
        int unsigned           after;
        int unsigned           held;
        int unsigned           oldest;
        logic [TIME_WIDTH-1:0] elapsed;
        logic [63:0]           divisor;
        logic [63:0]           ms;
        logic [63:0]           quotient;
        t_rate_word            word;
        if (window_reg == '0) begin
            span = 1;
        end else if (window_reg > MAX_WINDOW) begin
            span = MAX_WINDOW;
        end else begin
            span = 32'(window_reg);
        end
        slot = (next_slot < span) ? next_slot : 0;
        mark_store[POS_W'(slot)] = stamp;
        after = slot + 1;
        if (after >= span) begin
            after        = 0;
            ring_wrapped = 1'b1;
        end
        next_slot = after;
        held = ring_wrapped ? span : after;
        word = '0;
        if (held >= 2) begin
            // The oldest mark sits at the next write slot once the ring has wrapped.
            oldest  = ring_wrapped ? after : 0;
            elapsed = mark_store[POS_W'(slot)] - mark_store[POS_W'(oldest)];
            divisor = (tick_div_reg == '0) ? 64'd1 : 64'(tick_div_reg);
            ms      = 64'(elapsed) / divisor;
            if (ms != 0) begin
                quotient        = (64'(held - 1) * 64'(SCALE_Q8)) / ms;
                word.rate_q8    = (quotient > 64'(RATE_CEIL)) ? RATE_CEIL
                                                              : quotient[RATE_W-1:0];
                word.rate_valid = 1'b1;
            end
        end
        return word;
    endfunction

    // Follow register writes, predict on each accepted mark, compare each accepted word.
    always @(posedge i_clk) begin
        t_rate_word due;
        t_rate_word got;
        if (!i_rst_n) begin
            next_slot    = 0;
            ring_wrapped = 1'b0;
            window_reg   = WLEN_RESET;
            tick_div_reg = TPMS_RESET;
            rate_words_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_WINDOW_LENGTH: begin
                        // A new window length restarts the window empty.
                        window_reg   = i_cfg_data[WLEN_W-1:0];
                        next_slot    = 0;
                        ring_wrapped = 1'b0;
                    end
                    CFG_TICKS_PER_MS: begin
                        tick_div_reg = i_cfg_data[TPMS_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                rate_words_due = {rate_words_due, rate_for_mark(i_timestamp_ticks)};
            end
            if (i_out_valid && !i_out_stall) begin
                got.rate_q8    = i_rate_q8;
                got.rate_valid = i_rate_valid;
                if (rate_words_due.size() == 0) begin
                    if (mismatches < REPORT_LIMIT) begin
                        $display("Unexpected rate word: rate_q8=%0d rate_valid=%0b",
                                 got.rate_q8, got.rate_valid);
                    end
                    mismatches++;
                end else begin
                    due = rate_words_due.pop_front();
                    if (got !== due) begin
                        if (mismatches < REPORT_LIMIT) begin
                            $display("Rate word mismatch: expected rate_q8=%0d rate_valid=%0b, got rate_q8=%0d rate_valid=%0b",
                                     due.rate_q8, due.rate_valid, got.rate_q8, got.rate_valid);
                        end
                        mismatches++;
                    end
                end
            end
        end
        o_mismatch_count <= mismatches;
        o_words_due      <= rate_words_due.size();
    end

endmodule

>>> tb/sliding_window_frame_rate_meter_tb.sv
// Top of the frame rate meter testbench: clock, reset, register writes, mark stimulus, verdict.
`timescale 1ns / 100ps

module sliding_window_frame_rate_meter_tb;
    import swfrm_pkg::*;

    localparam int RESET_CYCLES   = 12;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int RANDOM_MARKS   = 650;
    localparam int MAX_RUN        = 90;
    localparam int MAX_TICKS      = (1 << TPMS_W) - 1;
    // Index with no register behind it; writes to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = CFG_IDX_W'(2);

    typedef enum int {
        SEQ_CADENCE,
        SEQ_BURST,
        SEQ_NOISE
    } t_seq_kind;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic [TIME_WIDTH-1:0] i_timestamp_ticks = '0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_WINDOW_LENGTH;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [RATE_W-1:0]     o_rate_q8;
    logic                  o_rate_valid;
    logic                  o_cfg_ready;

    int          mismatch_count;
    int          words_due;
    int          in_idle_pct = 9;
    int          out_idle_pct = 65;
    int          marks_sent = 0;
    int          cycle_count = 0;
    int unsigned tick_div = TPMS_RESET;
    int unsigned window_span = WLEN_RESET;

    sliding_window_frame_rate_meter u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_timestamp_ticks (i_timestamp_ticks),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_rate_q8         (o_rate_q8),
        .o_rate_valid      (o_rate_valid),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    sliding_window_frame_rate_meter_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .i_in_stall        (o_in_stall),
        .i_timestamp_ticks (i_timestamp_ticks),
        .i_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .i_rate_q8         (o_rate_q8),
        .i_rate_valid      (o_rate_valid),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_mismatch_count  (mismatch_count),
        .o_words_due       (words_due)
    );

    // 20 ns clock.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // The output side stalls at random with the current idle rate.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < out_idle_pct);
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [TIME_WIDTH-1:0] rand_stamp();
        return TIME_WIDTH'({$urandom, $urandom});
    endfunction

    // Offer one mark, idling first at random, and hold it until accepted.
    task automatic send_mark(input logic [TIME_WIDTH-1:0] stamp);
        while ($urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_timestamp_ticks <= stamp;
        do @(posedge i_clk); while (o_in_stall);
        marks_sent++;
    endtask

    // Stop offering marks and wait until every rate word has come out.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (words_due != 0);
    endtask

    task automatic cfg_word(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // Write both registers while the meter is idle, optionally poking the spare index too.
    task automatic write_regs(input logic [CFG_DATA_W-1:0] wlen_word,
                              input logic [CFG_DATA_W-1:0] tpms_word,
                              input bit                    touch_spare);
        logic [WLEN_W-1:0] wlen;
        wait_idle();
        cfg_word(CFG_TICKS_PER_MS, tpms_word);
        cfg_word(CFG_WINDOW_LENGTH, wlen_word);
        if (touch_spare) begin
            cfg_word(CFG_SPARE_INDEX, CFG_DATA_W'($urandom));
        end
        i_cfg_valid <= 1'b0;
        wlen = wlen_word[WLEN_W-1:0];
        tick_div = (tpms_word[TPMS_W-1:0] == '0) ? 1 : 32'(tpms_word[TPMS_W-1:0]);
        if (wlen == '0) begin
            window_span = 1;
        end else if (wlen > MAX_WINDOW) begin
            window_span = MAX_WINDOW;
        end else begin
            window_span = 32'(wlen);
        end
    endtask

    // A run of marks: steady frame cadence, tight bursts, or unrelated timestamps.
    task automatic play_marks(input t_seq_kind kind, input int n_marks);
        logic [TIME_WIDTH-1:0] stamp;
        int unsigned           frame_ms;
        logic [63:0]           step;
        frame_ms = $urandom_range(1, 100);
        if ($urandom_range(3) == 0) begin
            // Start just below the wrap point so the timestamp rolls over mid-run.
            stamp = TIME_WIDTH'(0) -
                    TIME_WIDTH'(64'($urandom_range(1, 20)) * frame_ms * tick_div);
        end else begin
            stamp = rand_stamp();
        end
        for (int k = 0; k < n_marks; k++) begin
            case (kind)
                SEQ_CADENCE: begin
                    send_mark(stamp);
                    step = 64'(frame_ms) * tick_div + $urandom_range(tick_div - 1);
                    if ($urandom_range(15) == 0) begin
                        step = step * 2;
                    end
                    if ($urandom_range(31) == 0) begin
                        step = '0;
                    end
                    stamp = stamp + TIME_WIDTH'(step);
                end
                SEQ_BURST: begin
                    send_mark(stamp);
                    stamp = stamp + TIME_WIDTH'($urandom_range(2 * tick_div));
                end
                default: begin
                    send_mark(rand_stamp());
                end
            endcase
        end
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] wlen_word;
        logic [CFG_DATA_W-1:0] tpms_word;
        logic [TIME_WIDTH-1:0] stamp;
        t_seq_kind             kind;
        int                    run_len;
        int                    goal_base;
        int                    pick;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: single mark, span of the full timestamp range, zero elapsed ms, normal rate.
        send_mark('0);
        send_mark('1);
        send_mark(TIME_WIDTH'(500));
        send_mark(TIME_WIDTH'(31000));

        // Window of two with one tick per ms; upper data bits must be ignored.
        write_regs(20'hFFF82, CFG_DATA_W'(1), 1'b1);
        send_mark(TIME_WIDTH'(100));
        send_mark(TIME_WIDTH'(100));
        send_mark(TIME_WIDTH'(101));
        send_mark('0);

        // Zero window length acts as one, zero ticks per ms acts as one.
        write_regs(20'h00080, '0, 1'b0);
        send_mark(TIME_WIDTH'(5));
        send_mark(TIME_WIDTH'(6));
        send_mark(TIME_WIDTH'(7));

        // Oversized window saturates; largest tick divider.
        write_regs(CFG_DATA_W'(127), CFG_DATA_W'(MAX_TICKS), 1'b0);
        send_mark('0);
        send_mark(TIME_WIDTH'(MAX_TICKS));
        send_mark(TIME_WIDTH'(2 * MAX_TICKS));

        // Highest rate: a full window of 64 marks spanning a single ms.
        write_regs(CFG_DATA_W'(MAX_WINDOW), CFG_DATA_W'(1), 1'b0);
        stamp = rand_stamp();
        repeat (MAX_WINDOW - 1) send_mark(stamp);
        send_mark(stamp + TIME_WIDTH'(1));

        // Random phases under three idling regimes.
        goal_base = marks_sent;
        for (int regime = 0; regime < 3; regime++) begin
            case (regime)
                0: begin
                    in_idle_pct  = 9;
                    out_idle_pct = 65;
                end
                1: begin
                    in_idle_pct  = 65;
                    out_idle_pct = 9;
                end
                default: begin
                    in_idle_pct  = 0;
                    out_idle_pct = 0;
                end
            endcase
            while (marks_sent < goal_base + (RANDOM_MARKS * (regime + 1)) / 3) begin
                wlen_word = CFG_DATA_W'($urandom);
                case ($urandom_range(9))
                    0:       wlen_word[WLEN_W-1:0] = '0;
                    1:       wlen_word[WLEN_W-1:0] = WLEN_W'(1);
                    2:       wlen_word[WLEN_W-1:0] = WLEN_W'(2);
                    3:       wlen_word[WLEN_W-1:0] = WLEN_W'(MAX_WINDOW);
                    4:       wlen_word[WLEN_W-1:0] = WLEN_W'($urandom_range(65, 127));
                    default: wlen_word[WLEN_W-1:0] = WLEN_W'($urandom_range(3, 16));
                endcase
                case ($urandom_range(7))
                    0:       tpms_word = '0;
                    1:       tpms_word = CFG_DATA_W'(1);
                    2:       tpms_word = CFG_DATA_W'(MAX_TICKS);
                    3:       tpms_word = CFG_DATA_W'($urandom);
                    default: tpms_word = CFG_DATA_W'($urandom_range(1, 2000));
                endcase
                write_regs(wlen_word, tpms_word, $urandom_range(15) == 0);

                // Mostly well-formed frame cadence, some bursts and some noise.
                pick = $urandom_range(19);
                if (pick < 14) begin
                    kind = SEQ_CADENCE;
                end else if (pick < 17) begin
                    kind = SEQ_BURST;
                end else begin
                    kind = SEQ_NOISE;
                end
                run_len = $urandom_range(1, 2 * window_span + 8);
                if (run_len > MAX_RUN) begin
                    run_len = MAX_RUN;
                end
                play_marks(kind, run_len);
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && words_due == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
